[rtl/core/sitd_pkg.sv]
// Shared types and constants for the signed integer to decimal ASCII core.
// No dependencies; used by the queue, front, back and top-level files.
`default_nettype none

package sitd_pkg;

  localparam int VALUE_W   = 32;
  localparam int CHAR_W    = 8;
  localparam int DIGIT_W   = 4;
  localparam int MAX_DIGITS = 10;
  localparam int IDX_W     = 4;
  localparam int PROD_W    = 2 * VALUE_W;
  localparam int QUOT_SHIFT = 35;
  localparam int QUOT_W    = PROD_W - QUOT_SHIFT;

  localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [IDX_W-1:0]   LAST_IDX   = 4'd9;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

[rtl/core/sitd_queue.sv]
// Small register-based FIFO of classified jobs between front and back.
// Depends on sitd_pkg for the job type.
`default_nettype none

module sitd_queue #(
  parameter int DEPTH = 2
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push_valid,
  output logic              push_ready,
  input  sitd_pkg::job_t    push_data,
  output logic              pop_valid,
  input  wire               pop_ready,
  output sitd_pkg::job_t    pop_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sitd_pkg::job_t   slots_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sitd_front.sv]
// Input side: accepts integers, splits them into sign and magnitude, queues jobs.
// Depends on sitd_pkg and sitd_queue.
`default_nettype none

module sitd_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [sitd_pkg::VALUE_W-1:0]     in_tdata,
  output logic                             job_valid,
  input  wire                              job_ready,
  output sitd_pkg::job_t                   job
);

  sitd_pkg::job_t cls;

  always_comb begin
    cls.neg = in_tdata[sitd_pkg::VALUE_W-1];
    cls.mag = cls.neg ? (~in_tdata + sitd_pkg::VALUE_W'(1)) : in_tdata;
  end

  sitd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_data  (cls),
    .pop_valid  (job_valid),
    .pop_ready  (job_ready),
    .pop_data   (job)
  );

endmodule

`default_nettype wire

[rtl/core/sitd_back.sv]
// Output side: peels decimal digits by reciprocal multiply, then emits characters.
// Depends on sitd_pkg.
`default_nettype none

module sitd_back (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              job_valid,
  output logic                             job_ready,
  input  sitd_pkg::job_t                   job,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [sitd_pkg::CHAR_W-1:0]      out_tdata,
  output logic                             out_tlast
);

  sitd_pkg::back_state_t               state_r, state_nxt;
  logic [sitd_pkg::VALUE_W-1:0]        mag_r, mag_nxt;
  logic                                neg_r, neg_nxt;
  logic                                sign_pend_r, sign_pend_nxt;
  logic [sitd_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  logic [sitd_pkg::PROD_W-1:0]         prod_r;
  logic [sitd_pkg::DIGIT_W-1:0]        digits_r [sitd_pkg::MAX_DIGITS];
  logic                                dig_we;
  logic [sitd_pkg::DIGIT_W-1:0]        dig_val;
  logic [sitd_pkg::QUOT_W-1:0]         quot;
  logic [sitd_pkg::DIGIT_W-1:0]        quot_ten_lo;
  logic                                ovalid_r, ovalid_nxt;
  logic [sitd_pkg::CHAR_W-1:0]         ochar_r, ochar_nxt;
  logic                                olast_r, olast_nxt;
  logic                                out_free;

  assign out_tvalid = ovalid_r;
  assign out_tdata  = ochar_r;
  assign out_tlast  = olast_r;
  assign out_free   = !ovalid_r || out_tready;
  assign job_ready  = (state_r == sitd_pkg::ST_IDLE);

  assign quot        = prod_r[sitd_pkg::PROD_W-1:sitd_pkg::QUOT_SHIFT];
  assign quot_ten_lo = {quot[2:0], 1'b0} + {quot[0], 3'b000};
  assign dig_val     = mag_r[sitd_pkg::DIGIT_W-1:0] - quot_ten_lo;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    idx_nxt       = idx_r;
    dig_we        = 1'b0;
    ovalid_nxt    = ovalid_r && !out_tready;
    ochar_nxt     = ochar_r;
    olast_nxt     = olast_r;
    unique case (state_r)
      sitd_pkg::ST_IDLE: begin
        if (job_valid) begin
          mag_nxt   = job.mag;
          neg_nxt   = job.neg;
          idx_nxt   = '0;
          state_nxt = sitd_pkg::ST_MUL;
        end
      end
      sitd_pkg::ST_MUL: begin
        state_nxt = sitd_pkg::ST_DIV;
      end
      sitd_pkg::ST_DIV: begin
        dig_we  = 1'b1;
        mag_nxt = sitd_pkg::VALUE_W'(quot);
        if (quot == '0 || idx_r == sitd_pkg::LAST_IDX) begin
          sign_pend_nxt = neg_r;
          state_nxt     = sitd_pkg::ST_EMIT;
        end else begin
          idx_nxt   = idx_r + sitd_pkg::IDX_W'(1);
          state_nxt = sitd_pkg::ST_MUL;
        end
      end
      sitd_pkg::ST_EMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          if (sign_pend_r) begin
            ochar_nxt     = sitd_pkg::CHAR_MINUS;
            olast_nxt     = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            ochar_nxt = sitd_pkg::CHAR_ZERO + sitd_pkg::CHAR_W'(digits_r[idx_r]);
            olast_nxt = (idx_r == '0);
            if (idx_r == '0) begin
              state_nxt = sitd_pkg::ST_IDLE;
            end else begin
              idx_nxt = idx_r - sitd_pkg::IDX_W'(1);
            end
          end
        end
      end
      default: state_nxt = sitd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sitd_pkg::ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r       <= mag_nxt;
    neg_r       <= neg_nxt;
    sign_pend_r <= sign_pend_nxt;
    idx_r       <= idx_nxt;
    ochar_r     <= ochar_nxt;
    olast_r     <= olast_nxt;
    prod_r      <= mag_r * sitd_pkg::RECIP_TEN;
    if (dig_we) begin
      digits_r[idx_r] <= dig_val;
    end
  end

endmodule

`default_nettype wire

[rtl/core/signed_int_to_decimal_ascii_core.sv]
// Top level of the signed integer to decimal ASCII core.
// Depends on sitd_pkg, sitd_front and sitd_back.
//
// Usage:
//   in_*  : one 32-bit two's complement integer per transaction in in_tdata.
//   out_* : one ASCII character per transaction, most significant first;
//           '-' leads negative values, out_tlast marks the final digit.
//   A number yields 1 to 11 transactions; zero yields the single '0'.
// Flow:
//   The back end takes a job in its idle state, then for each decimal
//   digit steps through a multiply state and a divide state on the shared
//   divide-by-ten multiplier, then moves each character into the output
//   register as that register frees. It takes the next job only after
//   returning to idle once the last character is registered.
//   A QUEUE_DEPTH-entry job queue lets the input keep accepting, until it
//   fills, while the back end converts or waits on out_tready.
// Reset:
//   rst_n low empties the queue, idles the back end and drops out_tvalid.
// Stall:
//   With out_tready low the pending character holds; once a job's last
//   character is registered, digits of the next job are still computed,
//   and the back end then waits in its emit phase until the output register frees.
`default_nettype none

module signed_int_to_decimal_ascii_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] value
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [7:0] character
  output logic        out_tlast
);

  logic           job_valid;
  logic           job_ready;
  sitd_pkg::job_t job;

  sitd_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  sitd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid),
    .job_ready  (job_ready),
    .job        (job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_char_legal : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == sitd_pkg::CHAR_MINUS) ||
                   ((out_tdata >= sitd_pkg::CHAR_ZERO) && (out_tdata <= sitd_pkg::CHAR_NINE)))
    else $error("illegal output character");

  a_minus_not_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata == sitd_pkg::CHAR_MINUS) |-> !out_tlast)
    else $error("minus sign marked last");

  a_ready_after_reset : assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (in_tready && !out_tvalid))
    else $error("not idle after reset");

endmodule

`default_nettype wire
